// ----- hdl/vls_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vls_pkg
// Shared widths, register indexes and reset values for the VGA line sequencer.
// ----------------------------------------------------------------------------
package vls_pkg;

  localparam int unsigned LINE_W      = 10;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned STRIDE_W    = 16;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned FLAGS_W     = 3;

  localparam int unsigned IN_TDATA_W  = 8;
  // hsync, vsync, black, row_start, row_address, frame_count = 68 bits
  localparam int unsigned OUT_FIELD_W = 4 + ADDR_W + COUNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BASE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE = CFG_INDEX_W'(1);

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(320);

  localparam int unsigned DEF_VISIBLE_LINES    = 480;
  localparam int unsigned DEF_VSYNC_START_LINE = 491;
  localparam int unsigned DEF_VSYNC_END_LINE   = 493;
  localparam int unsigned DEF_LAST_LINE        = 524;

  // event flag bit positions
  localparam int unsigned EV_LINE_START  = 0;
  localparam int unsigned EV_SYNC_END    = 1;
  localparam int unsigned EV_VIDEO_START = 2;

endpackage
`default_nettype wire

// ----- hdl/vga_line_sequencer_line_doubled.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vga_line_sequencer_line_doubled
// Horizontal-event driven line sequencer for 525-line VGA timing, with each
// framebuffer row shown on two consecutive lines.
// ----------------------------------------------------------------------------
// Each timer event transaction on the slave stream yields exactly one result
// transaction on the master stream in the cycle after it is accepted. The block
// takes one event per clock: sequencing state is updated at acceptance and the
// result sits in a single output register, so input ready follows
// "output empty or being taken this cycle". Priority among flags is line start,
// then sync end, then video start. Configuration writes (base address, row
// stride) are always accepted; a new base address applies at the next frame
// wrap, a new stride at the next odd visible line.
module vga_line_sequencer_line_doubled #(
  parameter int unsigned VISIBLE_LINES    = vls_pkg::DEF_VISIBLE_LINES,
  parameter int unsigned VSYNC_START_LINE = vls_pkg::DEF_VSYNC_START_LINE,
  parameter int unsigned VSYNC_END_LINE   = vls_pkg::DEF_VSYNC_END_LINE,
  parameter int unsigned LAST_LINE        = vls_pkg::DEF_LAST_LINE
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // event_flags [2:0], zero padded
  input  wire logic [vls_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // hsync_level [0], vsync_level [1], force_black [2], row_start [3],
  // row_address [35:4], frame_count [67:36], zero padded
  output logic [vls_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [vls_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [vls_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vls_pkg::*;

  localparam logic [LINE_W-1:0] VISIBLE_L = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] VS_START_L = LINE_W'(VSYNC_START_LINE);
  localparam logic [LINE_W-1:0] VS_END_L = LINE_W'(VSYNC_END_LINE);
  localparam logic [LINE_W-1:0] LAST_L = LINE_W'(LAST_LINE);

  logic [ADDR_W-1:0]   frame_base;
  logic [STRIDE_W-1:0] row_stride;

  logic [LINE_W-1:0]   line_counter, line_counter_next;
  logic [ADDR_W-1:0]   row_addr, row_addr_next;
  logic [COUNT_W-1:0]  frame_counter, frame_counter_next;
  logic                hsync, hsync_next;
  logic                vsync, vsync_next;

  logic                black_next;
  logic                start_next;
  logic [ADDR_W-1:0]   addr_next;

  logic [FLAGS_W-1:0]  flags;
  logic                in_fire;

  assign flags         = s_axis_tdata[FLAGS_W-1:0];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_comb begin
    line_counter_next  = line_counter;
    row_addr_next      = row_addr;
    frame_counter_next = frame_counter;
    hsync_next         = hsync;
    vsync_next         = vsync;
    black_next         = 1'b0;
    start_next         = 1'b0;
    addr_next          = '0;
    if (flags[EV_LINE_START]) begin
      black_next = 1'b1;
      hsync_next = 1'b0;
    end else if (flags[EV_SYNC_END]) begin
      hsync_next = 1'b1;
    end else if (flags[EV_VIDEO_START]) begin
      line_counter_next = line_counter + LINE_W'(1);
      if (line_counter < VISIBLE_L) begin
        start_next = 1'b1;
        addr_next  = row_addr;
        // advance after the second line of each row pair
        if (line_counter[0]) begin
          row_addr_next = row_addr + {{(ADDR_W-STRIDE_W){1'b0}}, row_stride};
        end
      end else if (line_counter == VISIBLE_L) begin
        frame_counter_next = frame_counter + COUNT_W'(1);
      end else if (line_counter == VS_START_L) begin
        vsync_next = 1'b0;
      end else if (line_counter == VS_END_L) begin
        vsync_next = 1'b1;
      end else if (line_counter == LAST_L) begin
        line_counter_next = '0;
        row_addr_next     = frame_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base    <= '0;
      row_stride    <= STRIDE_RESET;
      line_counter  <= '0;
      row_addr      <= '0;
      frame_counter <= '0;
      hsync         <= 1'b1;
      vsync         <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_BASE: frame_base <= cfg_data[ADDR_W-1:0];
          REG_ROW_STRIDE: row_stride <= cfg_data[STRIDE_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        line_counter  <= line_counter_next;
        row_addr      <= row_addr_next;
        frame_counter <= frame_counter_next;
        hsync         <= hsync_next;
        vsync         <= vsync_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result payload: loaded only on an accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, frame_counter_next, addr_next,
                       start_next, black_next, vsync_next, hsync_next};
    end
  end

endmodule
`default_nettype wire
